// ===== rtl/spmx_pkg.sv =====
// Shared constants, state type and unit handshake type for the splitmix random source.
package spmx_pkg;

   localparam int unsigned WORD_WIDTH     = 64;
   localparam int unsigned HALF_WIDTH     = 32;
   localparam int unsigned SPAN_WIDTH     = 33;
   localparam int unsigned FRAC_WIDTH     = 53;
   localparam int unsigned FRAC_SHIFT     = 11;
   localparam int unsigned CSR_ADDR_WIDTH = 4;

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
   localparam int unsigned MIX_SHIFT_A  = 30;
   localparam int unsigned MIX_SHIFT_B  = 27;
   localparam int unsigned MIX_SHIFT_C  = 31;

   localparam logic [63:0] SEED_RESET = 64'd1;

   typedef enum logic [1:0] {
      ACT_RAW      = 2'd0,
      ACT_INDEX    = 2'd1,
      ACT_FRACTION = 2'd2,
      ACT_RANGE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_WAIT_A,
      ST_WAIT_B,
      ST_WAIT_DIV,
      ST_RESULT
   } seq_state_type;

   // Start request to an iterative unit and its completion pulse.
   typedef struct packed {
      logic start;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SEED_ADDR = 4'h0;

endpackage

// ===== rtl/spmx_mul.sv =====
// Iterative 64x64 multiplier (low 64 bits) built from one shared 32x32 multiplier.
module spmx_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  spmx_pkg::unit_cmd_type     cmd,
   input  logic [63:0]                op_a,
   input  logic [63:0]                op_b,
   output spmx_pkg::unit_status_type  status,
   output logic [63:0]                product
);

   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x;
   logic [31:0] mul_y;

   // Partial products: lo*lo, lo*hi, hi*lo; only the low half of the cross terms matters.
   always_comb begin
      mul_x   = (step_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      mul_y   = (step_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         a_in    = op_a;
         b_in    = op_b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {32'd0, mul_x} * {32'd0, mul_y};
         step_in = step_ff + 2'd1;
         case (step_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            2'd3: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

// ===== rtl/spmx_div.sv =====
// Radix-2 restoring remainder unit: 64-bit dividend modulo a 33-bit divisor.
module spmx_div (
   input  logic                       clock,
   input  logic                       reset,
   input  spmx_pkg::unit_cmd_type     cmd,
   input  logic [63:0]                dividend,
   input  logic [32:0]                divisor,
   output spmx_pkg::unit_status_type  status,
   output logic [32:0]                remainder
);

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [32:0] div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [33:0] shifted;
   logic [33:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, div_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Keep the partial remainder below the divisor: subtract when it fits.
         rem_in = diff[33] ? shifted[32:0] : diff[32:0];
         quo_in = {quo_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== rtl/splitmix_random_source.sv =====
// Top level of the splitmix random source: sequencer, generator state, CSR port and result register.
//
// A 64-bit splitmix64 generator. Each request on the req_ channel advances the state
// once (add the golden gamma, xor-shift/multiply twice, final xor-shift) and returns
// one result transfer on the rsp_ channel: the raw word, the word modulo bound_n, the
// top 53 bits as a fraction, or range_low plus the word modulo the 33-bit span. Fields
// that do not belong to the requested action read zero. An index request with a zero
// bound, and a range request with range_low >= range_high, answer without advancing.
// The block takes one request at a time. Both multiplications run on a single
// shared 32x32 multiplier, three partial products each; index and range requests
// then go through the bit-serial remainder unit (one dividend bit per cycle). The
// degenerate cases go straight to the result state without the multiplier. While a
// finished result waits in the output register the next request can already be taken.
// The seed register sits at byte address 0 of the CSR port (64-bit data); writing it
// reloads the state, with zero loaded as one. Write it only while the block is idle.
module splitmix_random_source (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_action,
   input  logic [31:0]                          req_bound_n,
   input  logic signed [31:0]                   req_range_low,
   input  logic signed [31:0]                   req_range_high,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [63:0]                          rsp_random_word,
   output logic [31:0]                          rsp_index_value,
   output logic [52:0]                          rsp_fraction,
   output logic signed [31:0]                   rsp_range_value,
   // CSR port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [spmx_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [63:0]                          csr_pwdata,
   output logic [63:0]                          csr_prdata,
   output logic                                 csr_pready
);

   spmx_pkg::seq_state_type state_ff, state_in;

   // control registers
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] gen_ff, gen_in;

   // job and pending result registers
   logic [1:0]  action_ff, action_in;
   logic [31:0] bound_ff, bound_in;
   logic [31:0] low_ff, low_in;
   logic [32:0] span_ff, span_in;
   logic [63:0] res_word_ff, res_word_in;
   logic [31:0] res_index_ff, res_index_in;
   logic [52:0] res_frac_ff, res_frac_in;
   logic [31:0] res_range_ff, res_range_in;

   // output register
   logic [63:0] out_word_ff, out_word_in;
   logic [31:0] out_index_ff, out_index_in;
   logic [52:0] out_frac_ff, out_frac_in;
   logic [31:0] out_range_ff, out_range_in;

   // shared units
   spmx_pkg::unit_cmd_type    mul_cmd;
   spmx_pkg::unit_status_type mul_status;
   logic [63:0]               mul_a;
   logic [63:0]               mul_b;
   logic [63:0]               mul_p;
   spmx_pkg::unit_cmd_type    div_cmd;
   spmx_pkg::unit_status_type div_status;
   logic [63:0]               div_dividend;
   logic [32:0]               div_divisor;
   logic [32:0]               div_rem;

   logic        req_xfer;
   logic        rsp_xfer;
   logic        csr_write;
   logic [63:0] gamma_sum;
   logic [63:0] mixed_word;
   logic [32:0] req_span;

   spmx_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .status  (mul_status),
      .product (mul_p)
   );

   spmx_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .remainder (div_rem)
   );

   assign req_stall = (state_ff != spmx_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // Register at index 0 decodes on the index bit of the byte address (8-byte slots).
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[spmx_pkg::CSR_ADDR_WIDTH-1] == 1'b0);
   assign csr_prdata = (csr_paddr[spmx_pkg::CSR_ADDR_WIDTH-1] == 1'b0) ? seed_ff : 64'd0;

   assign gamma_sum  = gen_ff + spmx_pkg::GOLDEN_GAMMA;
   assign mixed_word = mul_p ^ (mul_p >> spmx_pkg::MIX_SHIFT_C);
   // Span at 33 bits so that the full signed range never wraps.
   assign req_span   = {req_range_high[31], req_range_high} -
                       {req_range_low[31], req_range_low} + 33'd1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      seed_in      = seed_ff;
      gen_in       = gen_ff;
      action_in    = action_ff;
      bound_in     = bound_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      res_word_in  = res_word_ff;
      res_index_in = res_index_ff;
      res_frac_in  = res_frac_ff;
      res_range_in = res_range_ff;
      out_word_in  = out_word_ff;
      out_index_in = out_index_ff;
      out_frac_in  = out_frac_ff;
      out_range_in = out_range_ff;
      mul_cmd.start = 1'b0;
      mul_a         = gamma_sum ^ (gamma_sum >> spmx_pkg::MIX_SHIFT_A);
      mul_b         = spmx_pkg::MIX_MUL_A;
      div_cmd.start = 1'b0;
      div_dividend  = mixed_word;
      div_divisor   = (action_ff == spmx_pkg::ACT_INDEX) ? {1'b0, bound_ff} : span_ff;

      // drop the result once the consumer takes it
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         spmx_pkg::ST_IDLE: begin
            if (req_xfer) begin
               action_in    = req_action;
               bound_in     = req_bound_n;
               low_in       = req_range_low;
               span_in      = req_span;
               res_word_in  = '0;
               res_index_in = '0;
               res_frac_in  = '0;
               res_range_in = '0;
               state_in     = spmx_pkg::ST_MIX;
               // degenerate requests skip to the result and hold the state
               if (req_action == spmx_pkg::ACT_INDEX && req_bound_n == 32'd0) begin
                  state_in = spmx_pkg::ST_RESULT;
               end else if (req_action == spmx_pkg::ACT_RANGE &&
                            req_range_low >= req_range_high) begin
                  res_range_in = req_range_low;
                  state_in     = spmx_pkg::ST_RESULT;
               end
            end
         end
         spmx_pkg::ST_MIX: begin
            mul_cmd.start = 1'b1;
            state_in      = spmx_pkg::ST_WAIT_A;
         end
         spmx_pkg::ST_WAIT_A: begin
            mul_a = mul_p ^ (mul_p >> spmx_pkg::MIX_SHIFT_B);
            mul_b = spmx_pkg::MIX_MUL_B;
            if (mul_status.done) begin
               mul_cmd.start = 1'b1;
               state_in      = spmx_pkg::ST_WAIT_B;
            end
         end
         spmx_pkg::ST_WAIT_B: begin
            if (mul_status.done) begin
               gen_in = mixed_word;
               case (action_ff)
                  spmx_pkg::ACT_RAW: begin
                     res_word_in = mixed_word;
                     state_in    = spmx_pkg::ST_RESULT;
                  end
                  spmx_pkg::ACT_FRACTION: begin
                     res_frac_in = mixed_word[63:spmx_pkg::FRAC_SHIFT];
                     state_in    = spmx_pkg::ST_RESULT;
                  end
                  default: begin
                     div_cmd.start = 1'b1;
                     state_in      = spmx_pkg::ST_WAIT_DIV;
                  end
               endcase
            end
         end
         spmx_pkg::ST_WAIT_DIV: begin
            if (div_status.done) begin
               if (action_ff == spmx_pkg::ACT_INDEX) begin
                  res_index_in = div_rem[31:0];
               end else begin
                  res_range_in = low_ff + div_rem[31:0];
               end
               state_in = spmx_pkg::ST_RESULT;
            end
         end
         spmx_pkg::ST_RESULT: begin
            // advance into the output register once it is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               out_word_in  = res_word_ff;
               out_index_in = res_index_ff;
               out_frac_in  = res_frac_ff;
               out_range_in = res_range_ff;
               rsp_valid_in = 1'b1;
               state_in     = spmx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spmx_pkg::ST_IDLE;
         end
      endcase

      // seed write reloads the generator; zero becomes one
      if (csr_write) begin
         seed_in = csr_pwdata;
         gen_in  = (csr_pwdata == 64'd0) ? 64'd1 : csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spmx_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= spmx_pkg::SEED_RESET;
         gen_ff       <= spmx_pkg::SEED_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         seed_ff      <= seed_in;
         gen_ff       <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      bound_ff     <= bound_in;
      low_ff       <= low_in;
      span_ff      <= span_in;
      res_word_ff  <= res_word_in;
      res_index_ff <= res_index_in;
      res_frac_ff  <= res_frac_in;
      res_range_ff <= res_range_in;
      out_word_ff  <= out_word_in;
      out_index_ff <= out_index_in;
      out_frac_ff  <= out_frac_in;
      out_range_ff <= out_range_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = out_word_ff;
   assign rsp_index_value = out_index_ff;
   assign rsp_fraction    = out_frac_ff;
   assign rsp_range_value = out_range_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for splitmix_random_source: directed and random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Splitmix64 mixing constants, kept here on their own so that a typo in the
   // package shows up as a mismatch instead of being copied into the prediction.
   localparam logic [63:0] SM_GAMMA      = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] SM_MUL_1      = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] SM_MUL_2      = 64'h94d0_49bb_1331_11eb;
   localparam int unsigned SM_SHIFT_1    = 30;
   localparam int unsigned SM_SHIFT_2    = 27;
   localparam int unsigned SM_SHIFT_3    = 31;
   localparam int unsigned SM_FRAC_SHIFT = 11;

   // A second register slot past the seed; the block has nothing there.
   localparam logic [spmx_pkg::CSR_ADDR_WIDTH-1:0] CSR_UNUSED_ADDR = 4'h8;

   localparam int unsigned RANDOM_ITEMS     = 400;
   localparam int unsigned RANDOM_PHASES    = 5;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned PRESSURE_ITEMS   = 8;
   localparam int unsigned SETTLE_CYCLES    = 120;
   localparam int unsigned MAX_REPORTED     = 10;

   typedef struct {
      spmx_pkg::action_type action;
      logic [31:0]          bound_n;
      logic signed [31:0]   range_low;
      logic signed [31:0]   range_high;
   } rng_request_type;

   typedef struct {
      int unsigned        serial;
      logic [63:0]        random_word;
      logic [31:0]        index_value;
      logic [52:0]        fraction;
      logic signed [31:0] range_value;
   } rng_outcome_type;

   // ---------------------------------------------------------------------------
   // DUT inputs start at known values; everything after time zero is driven
   // with nonblocking assignments at the rising edge.
   // ---------------------------------------------------------------------------
   logic                                clock          = 1'b0;
   logic                                reset          = 1'b1;
   logic                                req_valid      = 1'b0;
   logic                                req_stall;
   spmx_pkg::action_type                req_action     = spmx_pkg::ACT_RAW;
   logic [31:0]                         req_bound_n    = '0;
   logic signed [31:0]                  req_range_low  = '0;
   logic signed [31:0]                  req_range_high = '0;
   logic                                rsp_valid;
   logic                                rsp_stall      = 1'b0;
   logic [63:0]                         rsp_random_word;
   logic [31:0]                         rsp_index_value;
   logic [52:0]                         rsp_fraction;
   logic signed [31:0]                  rsp_range_value;
   logic                                csr_psel       = 1'b0;
   logic                                csr_penable    = 1'b0;
   logic                                csr_pwrite     = 1'b0;
   logic [spmx_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr      = '0;
   logic [63:0]                         csr_pwdata     = '0;
   logic [63:0]                         csr_prdata;
   logic                                csr_pready;

   // Predictor copy of the generator and the seed register.
   logic [63:0]  gen_state  = 64'd1;
   logic [63:0]  seed_value = 64'd1;

   // Results still owed by the block, oldest first.
   rng_outcome_type pending_results[$];

   int unsigned  next_serial        = 0;
   int unsigned  mismatch_count     = 0;
   int unsigned  results_checked    = 0;
   int unsigned  seed_writes        = 0;
   int unsigned  input_stall_cycles = 0;
   int unsigned  action_count[4]    = '{0, 0, 0, 0};

   // Pacing knobs shared between the stimulus and the result side.
   bit           send_gaps_on     = 1'b1;
   bit           stall_gaps_on    = 1'b1;
   bit           hold_off_pending = 1'b0;

   splitmix_random_source uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_bound_n    (req_bound_n),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_random_word(rsp_random_word),
      .rsp_index_value(rsp_index_value),
      .rsp_fraction   (rsp_fraction),
      .rsp_range_value(rsp_range_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // One splitmix64 step: add the gamma, then two xor-shift/multiply rounds
   // and a closing xor-shift, all modulo 2^64.
   function automatic logic [63:0] splitmix_step(input logic [63:0] s);
      logic [63:0] v;
      v = s + SM_GAMMA;
      v = (v ^ (v >> SM_SHIFT_1)) * SM_MUL_1;
      v = (v ^ (v >> SM_SHIFT_2)) * SM_MUL_2;
      return v ^ (v >> SM_SHIFT_3);
   endfunction

   // Work out the result of one accepted request and advance the generator
   // copy exactly when the block would. Fields of other actions stay zero.
   function automatic rng_outcome_type predict_outcome(input rng_request_type r);
      rng_outcome_type o;
      logic [63:0]     span;
      logic [63:0]     remainder;
      o.serial      = next_serial;
      o.random_word = '0;
      o.index_value = '0;
      o.fraction    = '0;
      o.range_value = '0;
      next_serial++;
      case (r.action)
         spmx_pkg::ACT_RAW: begin
            gen_state     = splitmix_step(gen_state);
            o.random_word = gen_state;
         end
         spmx_pkg::ACT_INDEX: begin
            // A zero bound answers zero and leaves the generator alone.
            if (r.bound_n != '0) begin
               gen_state     = splitmix_step(gen_state);
               remainder     = gen_state % {32'd0, r.bound_n};
               o.index_value = remainder[31:0];
            end
         end
         spmx_pkg::ACT_FRACTION: begin
            gen_state  = splitmix_step(gen_state);
            o.fraction = gen_state[63:SM_FRAC_SHIFT];
         end
         default: begin
            // An empty or one-value range gives the low end without a step.
            if (r.range_low >= r.range_high) begin
               o.range_value = r.range_low;
            end else begin
               // Span at full width so a range over all 2^32 values cannot wrap.
               span = {{32{r.range_high[31]}}, r.range_high}
                    - {{32{r.range_low[31]}}, r.range_low} + 64'd1;
               gen_state     = splitmix_step(gen_state);
               remainder     = gen_state % span;
               o.range_value = r.range_low + remainder[31:0];
            end
         end
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Pacing helpers
   // ---------------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 4);
      else
         return $urandom_range(20, 80);
   endfunction

   // Random request, biased toward the corners of each field.
   function automatic rng_request_type make_random_request();
      rng_request_type r;
      r.action = spmx_pkg::action_type'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
         0:       r.bound_n = '0;
         1:       r.bound_n = 32'd1;
         2:       r.bound_n = 32'hffff_ffff - $urandom_range(0, 3);
         3, 4:    r.bound_n = $urandom_range(2, 20);
         default: r.bound_n = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0: begin
            r.range_low  = $urandom;
            r.range_high = r.range_low;
         end
         1: begin
            r.range_high = $urandom;
            r.range_low  = r.range_high + $urandom_range(1, 1000);
         end
         2: begin
            r.range_low  = $urandom;
            r.range_high = r.range_low + $urandom_range(1, 15);
         end
         3: begin
            r.range_low  = $urandom_range(0, 1) ? 32'sh8000_0000 : $urandom;
            r.range_high = $urandom_range(0, 1) ? 32'sh7fff_ffff : $urandom;
         end
         default: begin
            r.range_low  = $urandom;
            r.range_high = $urandom;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Shared transfer tasks
   // ---------------------------------------------------------------------------

   task automatic flag_mismatch(input int unsigned serial, input string what,
                                input logic [63:0] want, input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED)
         $display("tb: mismatch at result %0d, %s: expected %h, got %h",
                  serial, what, want, got);
   endtask

   // Offer one request and hold it until the block takes it. Valid drops only
   // when a gap precedes the item, so back-to-back items keep it high.
   task automatic send_request(input rng_request_type r);
      int unsigned gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= r.action;
      req_bound_n    <= r.bound_n;
      req_range_low  <= r.range_low;
      req_range_high <= r.range_high;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), predict_outcome(r));
      action_count[r.action]++;
   endtask

   task automatic send_fields(input spmx_pkg::action_type act, input logic [31:0] bound,
                              input logic signed [31:0] low,
                              input logic signed [31:0] high);
      rng_request_type r;
      r.action     = act;
      r.bound_n    = bound;
      r.range_low  = low;
      r.range_high = high;
      send_request(r);
   endtask

   // Drop valid and wait until every owed result has come back. Every request
   // yields a result, so an empty queue means the block is idle.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Two-phase register write: setup, then access until pready.
   task automatic csr_write(input logic [spmx_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [63:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      seed_writes++;
      if (addr == spmx_pkg::CSR_SEED_ADDR) begin
         seed_value = data;
         gen_state  = (data == '0) ? 64'd1 : data;
      end
   endtask

   // Read the seed register back and compare with what was last written.
   task automatic verify_seed_register();
      logic [63:0] value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= spmx_pkg::CSR_SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (value !== seed_value)
         flag_mismatch(next_serial, "seed readback", seed_value, value);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: stall pacing and checking
   // ---------------------------------------------------------------------------

   // Drive rsp_stall. A requested hold-off keeps the receiver blocked for a
   // fixed count of cycles; otherwise stall in random stretches when enabled.
   initial begin : result_pacing
      int unsigned stretch;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_gaps_on && $urandom_range(0, 3) == 0) begin
            stretch = 1 + pick_gap();
            rsp_stall <= 1'b1;
            repeat (stretch) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare every result transfer, field by field, with the oldest expectation.
   always @(posedge clock) begin : result_check
      rng_outcome_type want;
      if (!reset) begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               flag_mismatch(results_checked, "result with nothing pending", '0,
                             rsp_random_word);
            end else begin
               want = pending_results.pop_front();
               if (rsp_random_word !== want.random_word)
                  flag_mismatch(want.serial, "random_word", want.random_word,
                                rsp_random_word);
               if (rsp_index_value !== want.index_value)
                  flag_mismatch(want.serial, "index_value", 64'(want.index_value),
                                64'(rsp_index_value));
               if (rsp_fraction !== want.fraction)
                  flag_mismatch(want.serial, "fraction", 64'(want.fraction),
                                64'(rsp_fraction));
               if (rsp_range_value !== want.range_value)
                  flag_mismatch(want.serial, "range_value", 64'(want.range_value),
                                64'(rsp_range_value));
            end
            results_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Out of reset the seed reads one and the stream starts from state one.
   task automatic test_reset_state();
      verify_seed_register();
      send_fields(spmx_pkg::ACT_RAW, $urandom, $urandom, $urandom);
      send_fields(spmx_pkg::ACT_RAW, 32'hffff_ffff, 32'shffff_ffff, 32'shffff_ffff);
   endtask

   // Every action, the field extremes, the zero bound and the degenerate ranges.
   task automatic test_special_cases();
      send_fields(spmx_pkg::ACT_RAW,      '0,            '0,             '0);
      send_fields(spmx_pkg::ACT_INDEX,    '0,            $urandom,       $urandom);
      send_fields(spmx_pkg::ACT_INDEX,    32'd1,         $urandom,       $urandom);
      send_fields(spmx_pkg::ACT_INDEX,    32'hffff_ffff, '0,             '0);
      send_fields(spmx_pkg::ACT_INDEX,    32'h8000_0000, $urandom,       $urandom);
      send_fields(spmx_pkg::ACT_INDEX,    32'd7,         $urandom,       $urandom);
      send_fields(spmx_pkg::ACT_FRACTION, $urandom,      $urandom,       $urandom);
      send_fields(spmx_pkg::ACT_FRACTION, 32'hffff_ffff, 32'shffff_ffff, 32'shffff_ffff);
      // low equal to high, low above high, then low equal to high at the negative end
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      '0,             '0);
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      32'sh7fff_ffff, 32'sh8000_0000);
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      32'sh8000_0000, 32'sh8000_0000);
      // full 32-bit span, and the narrowest spans at both ends and around zero
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      32'sh8000_0000, 32'sh7fff_ffff);
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      32'sh8000_0000, 32'sh8000_0001);
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      32'sh7fff_fffe, 32'sh7fff_ffff);
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      -32'sd1,        32'sd0);
      send_fields(spmx_pkg::ACT_RANGE,    $urandom,      -32'sd5,        32'sd5);
   endtask

   // Seed reloads: zero becomes one, the extremes, and a write to an empty slot.
   task automatic test_seed_register();
      wait_until_idle();
      csr_write(spmx_pkg::CSR_SEED_ADDR, '0);
      verify_seed_register();
      send_fields(spmx_pkg::ACT_RAW,      $urandom, $urandom, $urandom);
      send_fields(spmx_pkg::ACT_RAW,      $urandom, $urandom, $urandom);
      wait_until_idle();
      csr_write(spmx_pkg::CSR_SEED_ADDR, 64'hffff_ffff_ffff_ffff);
      verify_seed_register();
      send_fields(spmx_pkg::ACT_RAW,      $urandom, $urandom, $urandom);
      send_fields(spmx_pkg::ACT_FRACTION, $urandom, $urandom, $urandom);
      wait_until_idle();
      csr_write(spmx_pkg::CSR_SEED_ADDR, 64'h8000_0000_0000_0000);
      send_fields(spmx_pkg::ACT_INDEX,    32'd1000, $urandom, $urandom);
      wait_until_idle();
      // nothing lives here; the generator and the seed must not move
      csr_write(CSR_UNUSED_ADDR, {$urandom, $urandom});
      verify_seed_register();
      send_fields(spmx_pkg::ACT_RAW,      $urandom, $urandom, $urandom);
   endtask

   // Hold the receiver off while requests keep coming, so the result register
   // fills, the next computation finishes behind it and the input stalls.
   task automatic test_backpressure();
      wait_until_idle();
      send_gaps_on     = 1'b0;
      hold_off_pending = 1'b1;
      repeat (PRESSURE_ITEMS) send_request(make_random_request());
      wait_until_idle();
      send_gaps_on     = 1'b1;
   endtask

   // Random traffic in phases, each with its own seed and pacing: the first
   // with no idling at all, then sender-only, receiver-only and both.
   task automatic test_random_traffic();
      logic [63:0] phase_seed[RANDOM_PHASES];
      phase_seed[0] = {$urandom, $urandom};
      phase_seed[1] = '0;
      phase_seed[2] = 64'hffff_ffff_ffff_ffff;
      phase_seed[3] = {$urandom, $urandom};
      phase_seed[4] = 64'h0000_0000_0000_0001;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_idle();
         csr_write(spmx_pkg::CSR_SEED_ADDR, phase_seed[p]);
         send_gaps_on  = (p != 0) && (p != 2);
         stall_gaps_on = (p != 0) && (p != 1);
         repeat (RANDOM_ITEMS / RANDOM_PHASES) send_request(make_random_request());
      end
      send_gaps_on  = 1'b1;
      stall_gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin : run_tests
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_special_cases();
      test_seed_register();
      test_backpressure();
      test_random_traffic();

      // Drain, then give any stray result time to show up.
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("tb: %0d requests (raw %0d, index %0d, frac %0d, range %0d), %0d checked",
               next_serial, action_count[spmx_pkg::ACT_RAW],
               action_count[spmx_pkg::ACT_INDEX], action_count[spmx_pkg::ACT_FRACTION],
               action_count[spmx_pkg::ACT_RANGE], results_checked);
      $display("tb: %0d register writes, %0d stalled input cycles, %0d mismatches",
               seed_writes, input_stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   // Generous ceiling: even with the longest gaps and stalls on every item a
   // correct run stays several times below this.
   initial begin : watchdog
      #10ms;
      $display("tb: timeout with %0d results still owed", pending_results.size());
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/spmx_pkg.sv
rtl/spmx_mul.sv
rtl/spmx_div.sv
rtl/splitmix_random_source.sv
tb/tb.sv
